@@ sv/mbrtu_pkg.sv @@
`default_nettype none
package mbrtu_pkg;

  localparam int REG_COUNT_DEF   = 256;
  localparam int FRAME_BYTES_DEF = 256;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] MAX_READ_QTY  = 16'd125;
  localparam logic [15:0] MAX_WRITE_QTY = 16'd123;
  localparam logic [7:0]  EXC_FLAG      = 8'h80;
  localparam logic [7:0]  EXC_ILLEGAL_FUNCTION = 8'd1;
  localparam logic [7:0]  EXC_ILLEGAL_ADDRESS  = 8'd2;

  localparam logic [7:0] FC_READ_HOLD    = 8'd3;
  localparam logic [7:0] FC_RD_INPUT     = 8'd4;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'd6;
  localparam logic [7:0] FC_WRITE_MULTI  = 8'd16;

  typedef enum logic [1:0] {
    OP_RX_BYTE, OP_HOST_WR_HOLD, OP_HOST_WR_INPUT, OP_HOST_RD_HOLD
  } op_t;

  typedef enum logic [1:0] {FRD_NONE, FRD_WALK, FRD_WM_HI, FRD_WM_LO} frd_t;

  typedef enum logic [3:0] {
    TXS_DEV, TXS_FC, TXS_EXC_FC, TXS_CODE_FN, TXS_CODE_AD, TXS_BCNT,
    TXS_DHI, TXS_DLO, TXS_HDR, TXS_CRC_LO, TXS_CRC_HI
  } txs_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_HRD, ST_START, ST_WALK, ST_WALK_END, ST_CHECK,
    ST_EX_DEV, ST_EX_FC, ST_EX_CODE, ST_CRC_LO, ST_CRC_HI,
    ST_RD_DEV, ST_RD_FC, ST_RD_BCNT, ST_RD_ISSUE, ST_RD_HI, ST_RD_LO,
    ST_W1, ST_WM_HI, ST_WM_LO, ST_WM_WR, ST_ECHO, ST_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic frame_wr;
    logic host_wr_hold;
    logic host_wr_input;
    logic host_rd;
    logic host_out;
    logic walk_start;
    frd_t f_rd;
    logic len_clr;
    logic reg_rd;
    logic wr_single;
    logic wr_multi;
    logic ri_clr;
    logic ri_inc;
    logic tx_start;
    logic push;
    txs_t tx_sel;
    logic tx_last;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       out_busy;
    logic       walk_done;
    logic       len_lt4;
    logic       crc_ok;
    logic       adr_ok;
    logic       bc;
    logic [7:0] fc;
    logic       len_ge8;
    logic       len_ge9;
    logic       len_ge_cnt;
    logic       rd_bad;
    logic       wr1_bad;
    logic       wrm_bad;
    logic       ri_rd_last;
    logic       ri_echo_last;
  } status_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ sv/mbrtu_dp.sv @@
`default_nettype none
module mbrtu_dp #(
  parameter int REG_COUNT   = mbrtu_pkg::REG_COUNT_DEF,
  parameter int FRAME_BYTES = mbrtu_pkg::FRAME_BYTES_DEF
) (
  input  wire  logic              clk,
  input  wire  logic              rst_n,
  input  wire  mbrtu_pkg::cmd_t   cmd,
  output       mbrtu_pkg::status_t st,
  input  wire  logic              cfg_wr_en,
  input  wire  logic [7:0]        cfg_wr_data,
  input  wire  logic [7:0]        rx_byte,
  input  wire  logic [7:0]        reg_index,
  input  wire  logic [15:0]       reg_value,
  output       logic              out_valid,
  input  wire  logic              out_ready,
  output       logic [31:0]       out_bytes,
  output       logic [2:0]        out_count,
  output       logic              out_last,
  output       logic [15:0]       out_host_value,
  output       logic              out_is_host
);
  import mbrtu_pkg::*;

  localparam int FA = $clog2(FRAME_BYTES);
  localparam int LW = FA + 1;
  localparam int RA = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [7:0]    fmem [FRAME_BYTES];
  logic [15:0]   hmem [REG_COUNT];
  logic [15:0]   imem [REG_COUNT];

  logic [7:0]    dev_addr_r;
  logic [LW-1:0] frame_len_r;
  logic [RA-1:0] clr_idx_r;
  logic [7:0]    frd_r;
  logic [15:0]   hrd_r;
  logic [15:0]   ird_r;
  logic          hidx_ok_r;
  logic [LW-1:0] wk_r;
  logic [LW-1:0] wk_d_r;
  logic          wk_v_r;
  logic [15:0]   crc_r;
  logic [7:0]    rx_lo_r;
  logic [7:0]    rx_hi_r;
  logic [7:0]    hdr_r [7];
  logic [6:0]    ri_r;
  logic [7:0]    wm_hi_r;
  logic [15:0]   txcrc_r;
  logic [1:0]    n_r;
  logic          out_valid_r;
  logic [7:0]    out_b_r [4];
  logic [2:0]    out_cnt_r;
  logic          out_last_r;
  logic [15:0]   out_hv_r;
  logic          out_host_r;

  logic [RA-1:0] hidx;
  logic          hidx_ok;
  logic [15:0]   addr;
  logic [15:0]   qty;
  logic [RA-1:0] ra;
  logic [LW-1:0] lm2;
  logic [FA-1:0] fra;
  logic [16:0]   span;
  logic          h_we;
  logic [RA-1:0] h_wa;
  logic [15:0]   h_wd;
  logic          i_we;
  logic [RA-1:0] i_wa;
  logic [15:0]   i_wd;
  logic [7:0]    tx_b;
  logic [2:0]    n_new;

  assign hidx    = RA'(reg_index);
  assign hidx_ok = (32'(reg_index) < REG_COUNT);
  assign addr    = {hdr_r[2], hdr_r[3]};
  assign qty     = {hdr_r[4], hdr_r[5]};
  assign ra      = RA'(addr + 16'(ri_r));
  assign lm2     = frame_len_r - LW'(2);
  assign span    = 17'(addr) + 17'(qty);

  always_comb begin
    case (cmd.f_rd)
      FRD_WM_HI: fra = FA'(9'd7 + 9'({ri_r, 1'b0}));
      FRD_WM_LO: fra = FA'(9'd8 + 9'({ri_r, 1'b0}));
      default:   fra = wk_r[FA-1:0];
    endcase
  end

  always_comb begin
    h_we = 1'b0;
    h_wa = ra;
    h_wd = {hdr_r[4], hdr_r[5]};
    if (cmd.clr) begin
      h_we = 1'b1;
      h_wa = clr_idx_r;
      h_wd = '0;
    end else if (cmd.host_wr_hold) begin
      h_we = hidx_ok;
      h_wa = hidx;
      h_wd = reg_value;
    end else if (cmd.wr_single) begin
      h_we = 1'b1;
    end else if (cmd.wr_multi) begin
      h_we = 1'b1;
      h_wd = {wm_hi_r, frd_r};
    end
    i_we = 1'b0;
    i_wa = hidx;
    i_wd = reg_value;
    if (cmd.clr) begin
      i_we = 1'b1;
      i_wa = clr_idx_r;
      i_wd = '0;
    end else if (cmd.host_wr_input) begin
      i_we = hidx_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[h_wa] <= h_wd;
    end
    if (i_we) begin
      imem[i_wa] <= i_wd;
    end
    if (cmd.host_rd) begin
      hrd_r     <= hmem[hidx];
      hidx_ok_r <= hidx_ok;
    end else if (cmd.reg_rd) begin
      hrd_r <= hmem[ra];
      ird_r <= imem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.frame_wr && (frame_len_r < LW'(FRAME_BYTES))) begin
      fmem[frame_len_r[FA-1:0]] <= rx_byte;
    end
    frd_r <= fmem[fra];
  end

  always_comb begin
    case (cmd.tx_sel)
      TXS_DEV:     tx_b = dev_addr_r;
      TXS_FC:      tx_b = hdr_r[1];
      TXS_EXC_FC:  tx_b = hdr_r[1] | EXC_FLAG;
      TXS_CODE_FN: tx_b = EXC_ILLEGAL_FUNCTION;
      TXS_CODE_AD: tx_b = EXC_ILLEGAL_ADDRESS;
      TXS_BCNT:    tx_b = {hdr_r[5][6:0], 1'b0};
      TXS_DHI:     tx_b = (hdr_r[1] == FC_RD_INPUT) ? ird_r[15:8] : hrd_r[15:8];
      TXS_DLO:     tx_b = (hdr_r[1] == FC_RD_INPUT) ? ird_r[7:0] : hrd_r[7:0];
      TXS_HDR:     tx_b = hdr_r[ri_r[2:0]];
      TXS_CRC_LO:  tx_b = txcrc_r[7:0];
      TXS_CRC_HI:  tx_b = txcrc_r[15:8];
      default:     tx_b = '0;
    endcase
  end

  assign n_new = 3'(n_r) + 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= 8'd1;
      frame_len_r <= '0;
      clr_idx_r   <= '0;
      wk_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
    end else begin
      if (cfg_wr_en) begin
        dev_addr_r <= cfg_wr_data;
      end
      if (cmd.clr) begin
        clr_idx_r <= clr_idx_r + RA'(1);
      end
      if (cmd.len_clr) begin
        frame_len_r <= '0;
      end else if (cmd.frame_wr && (frame_len_r < LW'(FRAME_BYTES))) begin
        frame_len_r <= frame_len_r + LW'(1);
      end
      wk_v_r <= (cmd.f_rd == FRD_WALK);
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.tx_start) begin
        n_r <= '0;
      end
      if (cmd.host_out) begin
        out_valid_r <= 1'b1;
        for (int j = 0; j < 4; j++) begin
          out_b_r[j] <= '0;
        end
        out_cnt_r  <= '0;
        out_last_r <= 1'b0;
        out_hv_r   <= hidx_ok_r ? hrd_r : 16'd0;
        out_host_r <= 1'b1;
      end
      if (cmd.push) begin
        if (n_r == 2'd0) begin
          out_b_r[0] <= tx_b;
          out_b_r[1] <= '0;
          out_b_r[2] <= '0;
          out_b_r[3] <= '0;
        end else begin
          out_b_r[n_r] <= tx_b;
        end
        out_cnt_r  <= n_new;
        out_last_r <= cmd.tx_last;
        out_hv_r   <= '0;
        out_host_r <= 1'b0;
        if ((n_new == 3'd4) || cmd.tx_last) begin
          out_valid_r <= 1'b1;
          n_r         <= '0;
        end else begin
          n_r <= n_new[1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      wk_r  <= '0;
      crc_r <= CRC_INIT;
    end else if (cmd.f_rd == FRD_WALK) begin
      wk_r <= wk_r + LW'(1);
    end
    wk_d_r <= wk_r;
    if (wk_v_r) begin
      if (wk_d_r < lm2) begin
        crc_r <= crc_byte(crc_r, frd_r);
      end
      if (wk_d_r == lm2) begin
        rx_lo_r <= frd_r;
      end
      if (wk_d_r == frame_len_r - LW'(1)) begin
        rx_hi_r <= frd_r;
      end
      if (wk_d_r < LW'(7)) begin
        hdr_r[wk_d_r[2:0]] <= frd_r;
      end
    end
    if (cmd.ri_clr) begin
      ri_r <= '0;
    end else if (cmd.ri_inc) begin
      ri_r <= ri_r + 7'd1;
    end
    if (cmd.f_rd == FRD_WM_LO) begin
      wm_hi_r <= frd_r;
    end
    if (cmd.tx_start) begin
      txcrc_r <= CRC_INIT;
    end else if (cmd.push && (cmd.tx_sel != TXS_CRC_LO) && (cmd.tx_sel != TXS_CRC_HI)) begin
      txcrc_r <= crc_byte(txcrc_r, tx_b);
    end
  end

  always_comb begin
    st.clr_last     = (32'(clr_idx_r) == REG_COUNT - 1);
    st.out_busy     = out_valid_r;
    st.walk_done    = (wk_r == frame_len_r);
    st.len_lt4      = (frame_len_r < LW'(4));
    st.crc_ok       = (crc_r == {rx_hi_r, rx_lo_r});
    st.adr_ok       = (hdr_r[0] == dev_addr_r) || (hdr_r[0] == 8'd0);
    st.bc           = (hdr_r[0] == 8'd0);
    st.fc           = hdr_r[1];
    st.len_ge8      = (frame_len_r >= LW'(8));
    st.len_ge9      = (frame_len_r >= LW'(9));
    st.len_ge_cnt   = (10'(frame_len_r) >= 10'd9 + 10'(hdr_r[6]));
    st.rd_bad       = (qty == 16'd0) || (qty > MAX_READ_QTY) || (span > 17'(REG_COUNT));
    st.wr1_bad      = (32'(addr) >= REG_COUNT);
    st.wrm_bad      = (qty == 16'd0) || (qty > MAX_WRITE_QTY) ||
                      (17'(hdr_r[6]) != {qty, 1'b0}) || (span > 17'(REG_COUNT));
    st.ri_rd_last   = ((16'(ri_r) + 16'd1) == qty);
    st.ri_echo_last = (ri_r == 7'd5);
  end

  assign out_valid      = out_valid_r;
  assign out_bytes      = {out_b_r[3], out_b_r[2], out_b_r[1], out_b_r[0]};
  assign out_count      = out_cnt_r;
  assign out_last       = out_last_r;
  assign out_host_value = out_hv_r;
  assign out_is_host    = out_host_r;

endmodule
`default_nettype wire

@@ sv/mbrtu_ctrl.sv @@
`default_nettype none
module mbrtu_ctrl (
  input  wire  logic               clk,
  input  wire  logic               rst_n,
  input  wire  logic               in_valid,
  output       logic               in_ready,
  input  wire  mbrtu_pkg::op_t     op,
  input  wire  logic               fend,
  input  wire  mbrtu_pkg::status_t st,
  output       mbrtu_pkg::cmd_t    cmd
);
  import mbrtu_pkg::*;

  state_t state_r, state_nxt;
  logic   acc;

  assign in_ready = (state_r == ST_IDLE);
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.f_rd   = FRD_NONE;
    cmd.tx_sel = TXS_DEV;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          unique case (op)
            OP_RX_BYTE: begin
              cmd.frame_wr = 1'b1;
              if (fend) state_nxt = ST_START;
            end
            OP_HOST_WR_HOLD:  cmd.host_wr_hold = 1'b1;
            OP_HOST_WR_INPUT: cmd.host_wr_input = 1'b1;
            default: begin
              cmd.host_rd = 1'b1;
              state_nxt   = ST_HRD;
            end
          endcase
        end
      end
      ST_HRD: begin
        if (!st.out_busy) begin
          cmd.host_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_START: begin
        cmd.walk_start = 1'b1;
        state_nxt = st.len_lt4 ? ST_DONE : ST_WALK;
      end
      ST_WALK: begin
        if (st.walk_done) begin
          state_nxt = ST_WALK_END;
        end else begin
          cmd.f_rd = FRD_WALK;
        end
      end
      ST_WALK_END: state_nxt = ST_CHECK;
      ST_CHECK: begin
        cmd.ri_clr   = 1'b1;
        cmd.tx_start = 1'b1;
        if (!st.crc_ok || !st.adr_ok) begin
          state_nxt = ST_DONE;
        end else begin
          unique case (st.fc)
            FC_READ_HOLD, FC_RD_INPUT: begin
              if (!st.len_ge8 || st.bc) state_nxt = ST_DONE;
              else if (st.rd_bad)       state_nxt = ST_EX_DEV;
              else                      state_nxt = ST_RD_DEV;
            end
            FC_WRITE_SINGLE: begin
              if (!st.len_ge8)     state_nxt = ST_DONE;
              else if (st.wr1_bad) state_nxt = st.bc ? ST_DONE : ST_EX_DEV;
              else                 state_nxt = ST_W1;
            end
            FC_WRITE_MULTI: begin
              if (!st.len_ge9 || !st.len_ge_cnt) state_nxt = ST_DONE;
              else if (st.wrm_bad) state_nxt = st.bc ? ST_DONE : ST_EX_DEV;
              else                 state_nxt = ST_WM_HI;
            end
            default: state_nxt = st.bc ? ST_DONE : ST_EX_DEV;
          endcase
        end
      end
      ST_EX_DEV: begin
        cmd.tx_sel = TXS_DEV;
        if (!st.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = ST_EX_FC;
        end
      end
      ST_EX_FC: begin
        cmd.tx_sel = TXS_EXC_FC;
        if (!st.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = ST_EX_CODE;
        end
      end
      ST_EX_CODE: begin
        unique case (st.fc)
          FC_READ_HOLD, FC_RD_INPUT, FC_WRITE_SINGLE, FC_WRITE_MULTI:
            cmd.tx_sel = TXS_CODE_AD;
          default: cmd.tx_sel = TXS_CODE_FN;
        endcase
        if (!st.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = ST_CRC_LO;
        end
      end
      ST_CRC_LO: begin
        cmd.tx_sel = TXS_CRC_LO;
        if (!st.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = ST_CRC_HI;
        end
      end
      ST_CRC_HI: begin
        cmd.tx_sel  = TXS_CRC_HI;
        cmd.tx_last = 1'b1;
        if (!st.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_RD_DEV: begin
        cmd.tx_sel = TXS_DEV;
        if (!st.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = ST_RD_FC;
        end
      end
      ST_RD_FC: begin
        cmd.tx_sel = TXS_FC;
        if (!st.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = ST_RD_BCNT;
        end
      end
      ST_RD_BCNT: begin
        cmd.tx_sel = TXS_BCNT;
        if (!st.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = ST_RD_ISSUE;
        end
      end
      ST_RD_ISSUE: begin
        cmd.reg_rd = 1'b1;
        state_nxt  = ST_RD_HI;
      end
      ST_RD_HI: begin
        cmd.tx_sel = TXS_DHI;
        if (!st.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = ST_RD_LO;
        end
      end
      ST_RD_LO: begin
        cmd.tx_sel = TXS_DLO;
        if (!st.out_busy) begin
          cmd.push = 1'b1;
          if (st.ri_rd_last) begin
            state_nxt = ST_CRC_LO;
          end else begin
            cmd.ri_inc = 1'b1;
            state_nxt  = ST_RD_ISSUE;
          end
        end
      end
      ST_W1: begin
        cmd.wr_single = 1'b1;
        state_nxt = st.bc ? ST_DONE : ST_ECHO;
      end
      ST_WM_HI: begin
        cmd.f_rd  = FRD_WM_HI;
        state_nxt = ST_WM_LO;
      end
      ST_WM_LO: begin
        cmd.f_rd  = FRD_WM_LO;
        state_nxt = ST_WM_WR;
      end
      ST_WM_WR: begin
        cmd.wr_multi = 1'b1;
        if (st.ri_rd_last) begin
          cmd.ri_clr = 1'b1;
          state_nxt  = st.bc ? ST_DONE : ST_ECHO;
        end else begin
          cmd.ri_inc = 1'b1;
          state_nxt  = ST_WM_HI;
        end
      end
      ST_ECHO: begin
        cmd.tx_sel = TXS_HDR;
        if (!st.out_busy) begin
          cmd.push = 1'b1;
          if (st.ri_echo_last) begin
            state_nxt = ST_CRC_LO;
          end else begin
            cmd.ri_inc = 1'b1;
          end
        end
      end
      ST_DONE: begin
        cmd.len_clr = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/modbus_rtu_slave_frame_engine_top.sv @@
// Modbus RTU slave frame engine.
// in_ channel: one transaction per received byte or host operation. tuser
// carries the operation (0 byte, 1/2 host write holding/input, 3 host read
// holding), tlast marks the last byte of a frame.
// out_ channel: response bytes packed four per transaction, tlast on the final
// group of a frame; tuser high marks a host read reply carrying host_value.
// cfg_: write enable and data for the own slave address (reset 1).
// Bytes and host writes go straight into the frame buffer or register store. At
// frame end the engine walks the frame buffer through its single read port,
// one byte per cycle, then executes: a read issues each register read and then
// sends its high and low bytes, write multiple fetches each register's high and
// low bytes and then writes it; output bytes are packed into groups of four.
// A host read reply is registered, then presented once the output is free.
// After reset both register stores are cleared, one entry per cycle, until all
// REG_COUNT entries are zero; no input is taken during that pass, configuration is.
// When the receiver stalls, the engine holds its current group and waits;
// input is taken only while no frame is being executed.
`default_nettype none
module modbus_rtu_slave_frame_engine_top #(
  parameter int REG_COUNT   = mbrtu_pkg::REG_COUNT_DEF,
  parameter int FRAME_BYTES = mbrtu_pkg::FRAME_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [31:0] in_tdata,   // rx_byte, reg_index, reg_value
  input  wire logic [1:0]  in_tuser,   // operation
  input  wire logic        in_tlast,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [55:0] out_tdata,  // tx_byte0..3, tx_count, host_value, zero pad
  output      logic        out_tuser,  // is_host_reply
  output      logic        out_tlast
);
  import mbrtu_pkg::*;

  cmd_t        cmd;
  status_t     st;
  logic [31:0] o_bytes;
  logic [2:0]  o_cnt;
  logic [15:0] o_hv;

  mbrtu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .op       (op_t'(in_tuser)),
    .fend     (in_tlast),
    .st       (st),
    .cmd      (cmd)
  );

  mbrtu_dp #(
    .REG_COUNT   (REG_COUNT),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .rx_byte        (in_tdata[7:0]),
    .reg_index      (in_tdata[15:8]),
    .reg_value      (in_tdata[31:16]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_bytes      (o_bytes),
    .out_count      (o_cnt),
    .out_last       (out_tlast),
    .out_host_value (o_hv),
    .out_is_host    (out_tuser)
  );

  assign out_tdata = {5'd0, o_hv, o_cnt, o_bytes};

endmodule
`default_nettype wire
